@@ rtl/core/cwm_pkg.sv @@
// shared widths, structs, register indexes and arctangent table of the warp mapper
`timescale 1ns / 1ps
`default_nettype none
package cwm_pkg;

  // pixel coordinate width and rotation stage count
  localparam int COORD_BITS    = 12;
  localparam int CORDIC_STAGES = 16;
  localparam int STG_W         = $clog2(CORDIC_STAGES);

  // pi in Q16
  localparam int PI_Q16 = 205887;

  // register indexes of the configuration port
  localparam int IDX_W = 8;
  localparam logic [IDX_W-1:0] REG_COS      = 8'd0;
  localparam logic [IDX_W-1:0] REG_SIN      = 8'd1;
  localparam logic [IDX_W-1:0] REG_FOCAL    = 8'd2;
  localparam logic [IDX_W-1:0] REG_CENTER_X = 8'd3;
  localparam logic [IDX_W-1:0] REG_CENTER_Y = 8'd4;
  localparam logic [IDX_W-1:0] REG_GAIN     = 8'd5;
  localparam logic [IDX_W-1:0] REG_ORIGIN_X = 8'd6;
  localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 8'd7;
  localparam int CFG_W = 24;

  // back-projected ray component, signed Q.4
  localparam int BX_W = ((COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16) + 1;
  // product and rotated component widths
  localparam int PM_W = 18 + BX_W;
  localparam int T_W  = PM_W + 1;
  localparam int XY_W = T_W + 2;
  localparam int ANG_W = 21;

  // radius square root
  localparam int V_W     = ((2 * (BX_W - 1) > 32) ? 2 * (BX_W - 1) : 32) + 1;
  localparam int R_W     = (V_W + 1) / 2;
  localparam int SQRT_STAGES = R_W;
  localparam int REM_W   = R_W + 3;

  // height division
  localparam int MAG_W = BX_W - 1 + 16;
  localparam int N_W   = MAG_W + 2;
  localparam int D_W   = R_W + 1;
  localparam int DIV_STAGES = N_W;
  localparam int QL_W  = 17;
  localparam int QH_W  = N_W - QL_W;

  // position sums in Q.24
  localparam int P_W = 24 + N_W + 2;

  // line lengths between the stage groups
  localparam int ML_LEN  = SQRT_STAGES + DIV_STAGES;
  localparam int DLY_LEN = ML_LEN - CORDIC_STAGES;

  typedef struct packed {
    logic                    zero;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } cq_t;

  typedef struct packed {
    logic [2*R_W-1:0] v;
    logic [REM_W-1:0] rem;
    logic [R_W-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic           zero;
    logic [N_W-1:0] n;
    logic [D_W-1:0] d;
    logic [D_W-1:0] rem;
    logic [N_W-1:0] q;
  } dv_t;

  typedef struct packed {
    logic             valid;
    logic [23:0]      color;
    logic             refimg;
    logic             org;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } meta_t;

  typedef struct packed {
    logic signed [15:0] col;
    logic signed [15:0] row;
    logic [23:0]        color;
  } res_t;

  // rounded Q16 arctangent of 2^-i
  function automatic logic [16:0] atan_q16(input logic [4:0] idx);
    logic [16:0] a;
    case (idx)
      5'd0:  a = 17'd51472;
      5'd1:  a = 17'd30386;
      5'd2:  a = 17'd16055;
      5'd3:  a = 17'd8150;
      5'd4:  a = 17'd4091;
      5'd5:  a = 17'd2047;
      5'd6:  a = 17'd1024;
      5'd7:  a = 17'd512;
      5'd8:  a = 17'd256;
      5'd9:  a = 17'd128;
      5'd10: a = 17'd64;
      5'd11: a = 17'd32;
      5'd12: a = 17'd16;
      5'd13: a = 17'd8;
      5'd14: a = 17'd4;
      5'd15: a = 17'd2;
      5'd16: a = 17'd1;
      default: a = 17'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/cwm_cordic_cell.sv @@
// one vectoring rotation step of the azimuth chain
`timescale 1ns / 1ps
`default_nettype none
module cwm_cordic_cell (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [cwm_pkg::STG_W-1:0] stage,
  input  wire cwm_pkg::cq_t             d_in,
  output cwm_pkg::cq_t                  d_out
);

  cwm_pkg::cq_t d_r;
  cwm_pkg::cq_t d_nxt;
  logic signed [cwm_pkg::XY_W-1:0]  xs;
  logic signed [cwm_pkg::XY_W-1:0]  ys;
  logic signed [cwm_pkg::ANG_W-1:0] a;

  // rotate toward the x axis, floor shifts
  always_comb begin
    xs = d_in.x >>> stage;
    ys = d_in.y >>> stage;
    a  = cwm_pkg::ANG_W'($signed({1'b0, cwm_pkg::atan_q16(5'(stage))}));
    d_nxt = d_in;
    if (d_in.y >= 0) begin
      d_nxt.x = d_in.x + ys;
      d_nxt.y = d_in.y - xs;
      d_nxt.z = d_in.z + a;
    end else begin
      d_nxt.x = d_in.x - ys;
      d_nxt.y = d_in.y + xs;
      d_nxt.z = d_in.z - a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule
`default_nettype wire

@@ rtl/core/cwm_sqrt_cell.sv @@
// one result bit of the radius square root
`timescale 1ns / 1ps
`default_nettype none
module cwm_sqrt_cell (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire cwm_pkg::sq_t d_in,
  output cwm_pkg::sq_t      d_out
);

  cwm_pkg::sq_t d_r;
  cwm_pkg::sq_t d_nxt;
  logic [cwm_pkg::REM_W-1:0] rem2;
  logic [cwm_pkg::REM_W-1:0] trial;

  // bring down two bits, try root*4+1
  always_comb begin
    rem2  = {d_in.rem[cwm_pkg::REM_W-3:0], d_in.v[2*cwm_pkg::R_W-1 -: 2]};
    trial = cwm_pkg::REM_W'({d_in.root, 2'b01});
    d_nxt.v = {d_in.v[2*cwm_pkg::R_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      d_nxt.rem  = rem2 - trial;
      d_nxt.root = {d_in.root[cwm_pkg::R_W-2:0], 1'b1};
    end else begin
      d_nxt.rem  = rem2;
      d_nxt.root = {d_in.root[cwm_pkg::R_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule
`default_nettype wire

@@ rtl/core/cwm_div_cell.sv @@
// one quotient bit of the height division
`timescale 1ns / 1ps
`default_nettype none
module cwm_div_cell (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire cwm_pkg::dv_t d_in,
  output cwm_pkg::dv_t      d_out
);

  cwm_pkg::dv_t d_r;
  cwm_pkg::dv_t d_nxt;
  logic [cwm_pkg::D_W:0] rem2;
  logic [cwm_pkg::D_W:0] diff;

  // restoring step
  always_comb begin
    rem2  = {d_in.rem, d_in.n[cwm_pkg::N_W-1]};
    diff  = rem2 - {1'b0, d_in.d};
    d_nxt = d_in;
    d_nxt.n = {d_in.n[cwm_pkg::N_W-2:0], 1'b0};
    if (rem2 >= {1'b0, d_in.d}) begin
      d_nxt.rem = diff[cwm_pkg::D_W-1:0];
      d_nxt.q   = {d_in.q[cwm_pkg::N_W-2:0], 1'b1};
    end else begin
      d_nxt.rem = rem2[cwm_pkg::D_W-1:0];
      d_nxt.q   = {d_in.q[cwm_pkg::N_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule
`default_nettype wire

@@ rtl/core/cylindrical_warp_mapper.sv @@
// top level of the cylindrical panorama warp mapper
`timescale 1ns / 1ps
`default_nettype none
// Maps one source pixel per clock to a signed panorama column and row and
// passes its color along. A new pixel can be taken every cycle while the skid
// entry is empty. A result is offered after five front stages, one root cell
// per result bit (SQRT_STAGES, 17 at the default 12-bit coordinates), one
// divider cell per quotient bit (DIV_STAGES, 34), four tail stages and the
// output register; the azimuth cells run beside the root cells. One waiting
// result goes to a skid entry, and while that entry is full the whole chain and
// the input stall. Positions are not clipped and wrap to 16 bits. A pixel at
// (0,0) of the reference image loads the column shift so it lands on column 0.
module cylindrical_warp_mapper (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [cwm_pkg::COORD_BITS-1:0] in_pixel_col,
  input  wire logic [cwm_pkg::COORD_BITS-1:0] in_pixel_row,
  input  wire logic [23:0]                 in_pixel_color,
  input  wire logic                        in_reference_image,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [15:0]               out_col,
  output logic signed [15:0]               out_row,
  output logic [23:0]                      out_color,
  input  wire logic                        cfg_we,
  input  wire logic [cwm_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [cwm_pkg::CFG_W-1:0]   cfg_data
);

  localparam int BX_W = cwm_pkg::BX_W;
  localparam int PM_W = cwm_pkg::PM_W;
  localparam int T_W  = cwm_pkg::T_W;
  localparam int XY_W = cwm_pkg::XY_W;
  localparam int V_W  = cwm_pkg::V_W;
  localparam int R_W  = cwm_pkg::R_W;
  localparam int N_W  = cwm_pkg::N_W;
  localparam int P_W  = cwm_pkg::P_W;
  localparam int ANG_W = cwm_pkg::ANG_W;

  // configuration registers
  logic signed [17:0] cos_r;
  logic signed [17:0] sin_r;
  logic [15:0]        focal_r;
  logic [15:0]        center_x_r;
  logic [15:0]        center_y_r;
  logic [23:0]        gain_r;
  logic signed [19:0] origin_x_r;
  logic signed [19:0] origin_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r      <= 18'sd65536;
      sin_r      <= '0;
      focal_r    <= 16'd16384;
      center_x_r <= '0;
      center_y_r <= '0;
      gain_r     <= 24'd262144;
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cwm_pkg::REG_COS:      cos_r      <= cfg_data[17:0];
        cwm_pkg::REG_SIN:      sin_r      <= cfg_data[17:0];
        cwm_pkg::REG_FOCAL:    focal_r    <= cfg_data[15:0];
        cwm_pkg::REG_CENTER_X: center_x_r <= cfg_data[15:0];
        cwm_pkg::REG_CENTER_Y: center_y_r <= cfg_data[15:0];
        cwm_pkg::REG_GAIN:     gain_r     <= cfg_data[23:0];
        cwm_pkg::REG_ORIGIN_X: origin_x_r <= cfg_data[19:0];
        cwm_pkg::REG_ORIGIN_Y: origin_y_r <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // whole chain moves together unless the skid entry is occupied
  logic skid_valid_r;
  logic en;
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // front stages: ray, products, rotation, fold, rotation start
  cwm_pkg::meta_t s1_r, s2_r, s3_r, s4_r, s5_r;
  logic signed [BX_W-1:0] s1_bx_r, s1_by_r;
  logic signed [PM_W-1:0] s2_pcx_r, s2_psf_r, s2_pcf_r, s2_psx_r;
  logic [31:0]            s2_ff_r;
  logic [V_W-1:0]         s2_bb_r;
  logic signed [T_W-1:0]  s3_tx_r, s3_tz_r;
  logic [V_W-1:0]         s3_v_r, s4_v_r, s5_v_r;
  logic signed [XY_W-1:0] s4_x_r, s4_y_r;
  logic                   s4_fold_r;
  cwm_pkg::cq_t           s5_cq_r;

  logic signed [BX_W-1:0] bx_nxt, by_nxt, by_abs;
  logic signed [2*BX_W-1:0] bb_full;
  logic fold_nxt;
  logic signed [T_W-1:0] ntx, ntz;
  cwm_pkg::cq_t cq_nxt;

  always_comb begin
    bx_nxt = BX_W'($signed({1'b0, in_pixel_col, 4'b0000}))
           - BX_W'($signed({1'b0, center_x_r}));
    by_nxt = BX_W'($signed({1'b0, in_pixel_row, 4'b0000}))
           - BX_W'($signed({1'b0, center_y_r}));
    by_abs = (s1_by_r < 0) ? -s1_by_r : s1_by_r;
    bb_full = (2*BX_W)'(s1_bx_r) * (2*BX_W)'(s1_bx_r);
    fold_nxt = !s3_r.refimg && (s3_tx_r < 0) && (s3_tz_r < 0);
    ntx = -s3_tx_r;
    ntz = -s3_tz_r;
    // start of the azimuth chain: left half-plane turned by pi, fold adds pi
    cq_nxt.zero = (s4_x_r == 0) && (s4_y_r == 0);
    if (s4_x_r < 0) begin
      cq_nxt.x = -s4_x_r;
      cq_nxt.y = -s4_y_r;
      cq_nxt.z = (s4_y_r >= 0) ? ANG_W'(cwm_pkg::PI_Q16) : -ANG_W'(cwm_pkg::PI_Q16);
    end else begin
      cq_nxt.x = s4_x_r;
      cq_nxt.y = s4_y_r;
      cq_nxt.z = s4_fold_r ? ANG_W'(cwm_pkg::PI_Q16) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
      s4_r.valid <= 1'b0;
      s5_r.valid <= 1'b0;
    end else if (en) begin
      s1_r.valid <= in_valid;
      s2_r.valid <= s1_r.valid;
      s3_r.valid <= s2_r.valid;
      s4_r.valid <= s3_r.valid;
      s5_r.valid <= s4_r.valid;
    end
    if (en) begin
      // capture
      s1_r.color  <= in_pixel_color;
      s1_r.refimg <= in_reference_image;
      s1_r.org    <= in_reference_image && (in_pixel_col == '0) && (in_pixel_row == '0);
      s1_r.neg    <= 1'b0;
      s1_r.mag    <= '0;
      s1_bx_r     <= bx_nxt;
      s1_by_r     <= by_nxt;
      // products
      s2_r.color  <= s1_r.color;
      s2_r.refimg <= s1_r.refimg;
      s2_r.org    <= s1_r.org;
      s2_r.neg    <= s1_by_r < 0;
      s2_r.mag    <= {by_abs[BX_W-2:0], 16'h0000};
      s2_pcx_r    <= PM_W'(cos_r) * PM_W'(s1_bx_r);
      s2_psf_r    <= PM_W'(sin_r) * PM_W'($signed({1'b0, focal_r}));
      s2_pcf_r    <= PM_W'(cos_r) * PM_W'($signed({1'b0, focal_r}));
      s2_psx_r    <= PM_W'(sin_r) * PM_W'(s1_bx_r);
      s2_ff_r     <= 32'(focal_r) * 32'(focal_r);
      s2_bb_r     <= V_W'(bb_full);
      // rotated ray and squared radius
      s3_r.color  <= s2_r.color;
      s3_r.refimg <= s2_r.refimg;
      s3_r.org    <= s2_r.org;
      s3_r.neg    <= s2_r.neg;
      s3_r.mag    <= s2_r.mag;
      s3_tx_r     <= T_W'(s2_pcx_r) + T_W'(s2_psf_r);
      s3_tz_r     <= T_W'(s2_pcf_r) - T_W'(s2_psx_r);
      s3_v_r      <= V_W'(s2_ff_r) + s2_bb_r;
      // fold select
      s4_r.color  <= s3_r.color;
      s4_r.refimg <= s3_r.refimg;
      s4_r.org    <= s3_r.org;
      s4_r.neg    <= s3_r.neg;
      s4_r.mag    <= s3_r.mag;
      s4_fold_r   <= fold_nxt;
      s4_x_r      <= fold_nxt ? XY_W'(ntz) : XY_W'(s3_tz_r);
      s4_y_r      <= fold_nxt ? XY_W'(ntx) : XY_W'(s3_tx_r);
      s4_v_r      <= s3_v_r;
      // chain start
      s5_r.color  <= s4_r.color;
      s5_r.refimg <= s4_r.refimg;
      s5_r.org    <= s4_r.org;
      s5_r.neg    <= s4_r.neg;
      s5_r.mag    <= s4_r.mag;
      s5_cq_r     <= cq_nxt;
      s5_v_r      <= s4_v_r;
    end
  end

  // azimuth cells
  cwm_pkg::cq_t cq [0:cwm_pkg::CORDIC_STAGES];
  assign cq[0] = s5_cq_r;

  for (genvar k = 0; k < cwm_pkg::CORDIC_STAGES; k++) begin : g_cordic
    cwm_cordic_cell u_cell (
      .clk   (clk),
      .en    (en),
      .stage (cwm_pkg::STG_W'(k)),
      .d_in  (cq[k]),
      .d_out (cq[k+1])
    );
  end

  // radius cells
  cwm_pkg::sq_t sq [0:cwm_pkg::SQRT_STAGES];
  assign sq[0].v    = (2*R_W)'(s5_v_r);
  assign sq[0].rem  = '0;
  assign sq[0].root = '0;

  for (genvar k = 0; k < cwm_pkg::SQRT_STAGES; k++) begin : g_sqrt
    cwm_sqrt_cell u_cell (
      .clk   (clk),
      .en    (en),
      .d_in  (sq[k]),
      .d_out (sq[k+1])
    );
  end

  // item data travelling beside the cells
  cwm_pkg::meta_t mline_r [0:cwm_pkg::ML_LEN-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cwm_pkg::ML_LEN; i++) begin
        mline_r[i] <= '0;
      end
    end else if (en) begin
      mline_r[0] <= s5_r;
      for (int i = 1; i < cwm_pkg::ML_LEN; i++) begin
        mline_r[i] <= mline_r[i-1];
      end
    end
  end

  // height division cells, fed by the root and the row magnitude
  cwm_pkg::dv_t dv [0:cwm_pkg::DIV_STAGES];
  logic [R_W-1:0] root_w;
  assign root_w     = sq[cwm_pkg::SQRT_STAGES].root;
  assign dv[0].zero = (root_w == '0);
  assign dv[0].n    = N_W'({mline_r[cwm_pkg::SQRT_STAGES-1].mag, 1'b0}) + N_W'(root_w);
  assign dv[0].d    = {root_w, 1'b0};
  assign dv[0].rem  = '0;
  assign dv[0].q    = '0;

  for (genvar k = 0; k < cwm_pkg::DIV_STAGES; k++) begin : g_div
    cwm_div_cell u_cell (
      .clk   (clk),
      .en    (en),
      .d_in  (dv[k]),
      .d_out (dv[k+1])
    );
  end

  // azimuth waits for the height
  logic signed [ANG_W-1:0] dline_r [0:cwm_pkg::DLY_LEN-1];
  cwm_pkg::cq_t cq_end;
  assign cq_end = cq[cwm_pkg::CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      dline_r[0] <= cq_end.zero ? '0 : cq_end.z;
      for (int i = 1; i < cwm_pkg::DLY_LEN; i++) begin
        dline_r[i] <= dline_r[i-1];
      end
    end
  end

  // tail: gain products, origin add, rounding
  cwm_pkg::meta_t e1_r, e2_r, e3_r, e4_r, m_end;
  logic [N_W-1:0]          q_end;
  logic [24+cwm_pkg::QL_W-1:0] e1_pl_r;
  logic [24+cwm_pkg::QH_W-1:0] e1_ph_r;
  logic signed [24+ANG_W:0]    e1_pd_r, e2_pd_r;
  logic signed [P_W-1:0]   e2_m_r, e3_sx_r, e3_sy_r;
  logic signed [15:0]      e4_nx_r, e4_ny_r;
  logic signed [P_W-1:0]   my, rx, ry;

  assign m_end = mline_r[cwm_pkg::ML_LEN-1];
  assign q_end = dv[cwm_pkg::DIV_STAGES].zero ? '0 : dv[cwm_pkg::DIV_STAGES].q;

  always_comb begin
    my = e2_r.neg ? -e2_m_r : e2_m_r;
    // half away from zero: floor of (s + half - sign)
    rx = e3_sx_r + (P_W'(1) <<< 23) - P_W'({1'b0, e3_sx_r[P_W-1]});
    ry = e3_sy_r + (P_W'(1) <<< 23) - P_W'({1'b0, e3_sy_r[P_W-1]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r.valid <= 1'b0;
      e2_r.valid <= 1'b0;
      e3_r.valid <= 1'b0;
      e4_r.valid <= 1'b0;
    end else if (en) begin
      e1_r.valid <= m_end.valid;
      e2_r.valid <= e1_r.valid;
      e3_r.valid <= e2_r.valid;
      e4_r.valid <= e3_r.valid;
    end
    if (en) begin
      e1_r.color  <= m_end.color;
      e1_r.refimg <= m_end.refimg;
      e1_r.org    <= m_end.org;
      e1_r.neg    <= m_end.neg;
      e1_r.mag    <= '0;
      e1_pl_r     <= (24+cwm_pkg::QL_W)'(gain_r)
                   * (24+cwm_pkg::QL_W)'(q_end[cwm_pkg::QL_W-1:0]);
      e1_ph_r     <= (24+cwm_pkg::QH_W)'(gain_r)
                   * (24+cwm_pkg::QH_W)'(q_end[N_W-1:cwm_pkg::QL_W]);
      e1_pd_r     <= (25+ANG_W)'($signed({1'b0, gain_r}))
                   * (25+ANG_W)'(dline_r[cwm_pkg::DLY_LEN-1]);
      e2_r.color  <= e1_r.color;
      e2_r.refimg <= e1_r.refimg;
      e2_r.org    <= e1_r.org;
      e2_r.neg    <= e1_r.neg;
      e2_r.mag    <= '0;
      e2_m_r      <= (P_W'(e1_ph_r) << cwm_pkg::QL_W) + P_W'(e1_pl_r);
      e2_pd_r     <= e1_pd_r;
      e3_r.color  <= e2_r.color;
      e3_r.refimg <= e2_r.refimg;
      e3_r.org    <= e2_r.org;
      e3_r.neg    <= e2_r.neg;
      e3_r.mag    <= e2_r.mag;
      e3_sx_r     <= P_W'(e2_pd_r) + (P_W'(origin_x_r) <<< 20);
      e3_sy_r     <= my + (P_W'(origin_y_r) <<< 20);
      e4_r.color  <= e3_r.color;
      e4_r.refimg <= e3_r.refimg;
      e4_r.org    <= e3_r.org;
      e4_r.neg    <= e3_r.neg;
      e4_r.mag    <= e3_r.mag;
      e4_nx_r     <= rx[39:24];
      e4_ny_r     <= ry[39:24];
    end
  end

  // column shift latch and final result
  logic [15:0]  shift_r;
  cwm_pkg::res_t p_res;
  logic p_in;

  assign p_in        = en && e4_r.valid;
  assign p_res.col   = e4_r.org ? 16'sd0 : e4_nx_r + $signed(shift_r);
  assign p_res.row   = e4_ny_r;
  assign p_res.color = e4_r.color;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
    end else if (p_in && e4_r.org) begin
      shift_r <= -e4_nx_r;
    end
  end

  // output register with one skid entry
  logic          out_valid_r;
  cwm_pkg::res_t out_r, skid_r;
  logic          take;
  assign take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= p_in;
      end
    end else if (p_in) begin
      skid_valid_r <= 1'b1;
    end
    if (!out_valid_r || take) begin
      out_r <= skid_valid_r ? skid_r : p_res;
    end else if (p_in) begin
      skid_r <= p_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_col   = out_r.col;
  assign out_row   = out_r.row;
  assign out_color = out_r.color;

endmodule
`default_nettype wire

@@ sim/cylindrical_warp_mapper_tb.sv @@
// self-checking testbench for the cylindrical panorama warp mapper
`timescale 1ns / 1ps
module cylindrical_warp_mapper_tb;

  localparam int  CYCLE_LIMIT = 400000;
  localparam int  DRAIN_WAIT  = 80;
  localparam longint PI_FIX   = 205887;

  typedef enum int {SET_RESET, SET_FOLD, SET_ZERO} setup_t;

  typedef struct {
    setup_t      setup;
    int unsigned col;
    int unsigned row;
    int unsigned color;
    bit          refimg;
    bit          typed;
    int          ecol;
    int          erow;
  } pixel_row_t;

  // directed pixels: reset geometry, a turned camera for the fold, zero focal length
  pixel_row_t directed [22] = '{
    '{SET_RESET, 0, 0, 24'h000000, 1'b1, 1'b1, 0, 0},
    '{SET_RESET, 4095, 0, 24'hffffff, 1'b0, 1'b0, 0, 0},
    '{SET_RESET, 0, 4095, 24'h123456, 1'b0, 1'b0, 0, 0},
    '{SET_RESET, 4095, 4095, 24'habcdef, 1'b1, 1'b0, 0, 0},
    '{SET_RESET, 2048, 2048, 24'h800001, 1'b0, 1'b0, 0, 0},
    '{SET_RESET, 1, 1, 24'h7ffffe, 1'b1, 1'b0, 0, 0},
    '{SET_RESET, 2730, 1365, 24'haaaaaa, 1'b0, 1'b0, 0, 0},
    '{SET_RESET, 1365, 2730, 24'h555555, 1'b1, 1'b0, 0, 0},
    '{SET_FOLD, 4095, 100, 24'h010203, 1'b0, 1'b0, 0, 0},
    '{SET_FOLD, 3000, 4095, 24'h040506, 1'b0, 1'b0, 0, 0},
    '{SET_FOLD, 4095, 100, 24'h070809, 1'b1, 1'b0, 0, 0},
    '{SET_FOLD, 2048, 2048, 24'h0a0b0c, 1'b0, 1'b0, 0, 0},
    '{SET_FOLD, 2048, 0, 24'h0d0e0f, 1'b1, 1'b0, 0, 0},
    '{SET_FOLD, 0, 0, 24'h101112, 1'b0, 1'b0, 0, 0},
    '{SET_FOLD, 100, 4095, 24'h131415, 1'b1, 1'b0, 0, 0},
    '{SET_FOLD, 0, 0, 24'h161718, 1'b1, 1'b0, 0, 0},
    '{SET_FOLD, 4095, 0, 24'h191a1b, 1'b0, 1'b0, 0, 0},
    '{SET_ZERO, 5, 5, 24'h1c1d1e, 1'b0, 1'b0, 0, 0},
    '{SET_ZERO, 5, 4095, 24'h1f2021, 1'b1, 1'b0, 0, 0},
    '{SET_ZERO, 5, 0, 24'h222324, 1'b0, 1'b0, 0, 0},
    '{SET_ZERO, 6, 5, 24'h252627, 1'b0, 1'b0, 0, 0},
    '{SET_ZERO, 0, 0, 24'h28292a, 1'b1, 1'b0, 0, 0}
  };

  longint atan_tab [24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [cwm_pkg::COORD_BITS-1:0] in_pixel_col;
  logic [cwm_pkg::COORD_BITS-1:0] in_pixel_row;
  logic [23:0]           in_pixel_color;
  logic                  in_reference_image;
  logic                  out_valid;
  logic                  out_stall;
  logic signed [15:0]    out_col;
  logic signed [15:0]    out_row;
  logic [23:0]           out_color;
  logic                  cfg_we;
  logic [cwm_pkg::IDX_W-1:0] cfg_index;
  logic [cwm_pkg::CFG_W-1:0] cfg_data;

  // mirror of the geometry registers and the latched column shift
  longint      cam_cos, cam_sin, origin_x, origin_y;
  longint      focal, cen_x, cen_y, gain;
  logic [15:0] col_shift;

  cwm_pkg::res_t pending_pos [$];
  int          errors;
  int          checked;
  int          pixels_sent;
  int          cycles;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          hold_left;

  cylindrical_warp_mapper dut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d positions outstanding", $time, pending_pos.size());
      $display("FAILURE");
      $finish;
    end
  end

  // atan2 by vectoring rotation, angle in Q16
  function automatic longint azimuth(input longint y_in, input longint x_in);
    longint x, y, z, xs, ys;
    x = x_in;
    y = y_in;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_FIX : -PI_FIX;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < cwm_pkg::CORDIC_STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + atan_tab[i];
      end else begin
        x = x - ys; y = y + xs; z = z - atan_tab[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned v_in);
    longint unsigned v, res, b;
    v = v_in;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Q.24 to integer, half away from zero
  function automatic longint round_q24(input longint v);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << 23)) >> 24;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  // panorama position of one pixel; the origin pixel of the reference image latches the shift
  function automatic cwm_pkg::res_t warp_pixel(input int unsigned col, input int unsigned row,
                                               input int unsigned color, input bit refimg);
    longint bx, by, tx, tz, delta, h, nx, ny;
    longint unsigned r, mag, q;
    logic [63:0] nxb, nyb;
    cwm_pkg::res_t p;
    bx = longint'(col) * 16 - cen_x;
    by = longint'(row) * 16 - cen_y;
    tx = cam_cos * bx + cam_sin * focal;
    tz = cam_cos * focal - cam_sin * bx;
    if (!refimg && tx < 0 && tz < 0) delta = azimuth(-tx, -tz) + PI_FIX;
    else delta = azimuth(tx, tz);
    r = floor_root(focal * focal + bx * bx);
    h = 0;
    if (r != 0) begin
      mag = ((by < 0) ? -by : by) << 16;
      q = (2 * mag + r) / (2 * r);
      h = (by < 0) ? -longint'(q) : longint'(q);
    end
    nx = round_q24(gain * delta + origin_x * 1048576);
    ny = round_q24(gain * h + origin_y * 1048576);
    nxb = nx;
    nyb = ny;
    if (refimg && col == 0 && row == 0) col_shift = -nxb[15:0];
    p.col = nxb[15:0] + col_shift;
    p.row = nyb[15:0];
    p.color = color[23:0];
    return p;
  endfunction

  // result side: compare and stall
  always @(posedge clk) begin
    cwm_pkg::res_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_pos.size() == 0) begin
          $display("%0t: unexpected result col %0d row %0d color %h", $time,
                   out_col, out_row, out_color);
          errors++;
        end else begin
          e = pending_pos.pop_front();
          checked++;
          if (out_col !== e.col) begin
            $display("%0t: out_col expected %0d actual %0d", $time, e.col, out_col);
            errors++;
          end
          if (out_row !== e.row) begin
            $display("%0t: out_row expected %0d actual %0d", $time, e.row, out_row);
            errors++;
          end
          if (out_color !== e.color) begin
            $display("%0t: out_color expected %h actual %h", $time, e.color, out_color);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // offer one pixel and wait for its transfer
  task automatic send_pixel(input int unsigned col, input int unsigned row,
                            input int unsigned color, input bit refimg,
                            input bit typed, input int ecol, input int erow);
    cwm_pkg::res_t p;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_col <= col[cwm_pkg::COORD_BITS-1:0];
    in_pixel_row <= row[cwm_pkg::COORD_BITS-1:0];
    in_pixel_color <= color[23:0];
    in_reference_image <= refimg;
    do @(posedge clk); while (in_stall);
    p = warp_pixel(col, row, color, refimg);
    if (typed) begin
      p.col = ecol[15:0];
      p.row = erow[15:0];
    end
    pending_pos = {pending_pos, p};
    pixels_sent++;
  endtask

  // let the pipeline empty before a register write
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cwm_pkg::IDX_W-1:0] idx, input longint v);
    logic [63:0] vb;
    vb = v;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= vb[cwm_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cwm_pkg::REG_COS:      cam_cos  = longint'($signed(vb[17:0]));
      cwm_pkg::REG_SIN:      cam_sin  = longint'($signed(vb[17:0]));
      cwm_pkg::REG_FOCAL:    focal    = vb[15:0];
      cwm_pkg::REG_CENTER_X: cen_x    = vb[15:0];
      cwm_pkg::REG_CENTER_Y: cen_y    = vb[15:0];
      cwm_pkg::REG_GAIN:     gain     = vb[23:0];
      cwm_pkg::REG_ORIGIN_X: origin_x = longint'($signed(vb[19:0]));
      cwm_pkg::REG_ORIGIN_Y: origin_y = longint'($signed(vb[19:0]));
      default: ;
    endcase
  endtask

  task automatic write_all(input longint c, input longint s, input longint f,
                           input longint cx, input longint cy, input longint g,
                           input longint ox, input longint oy);
    drain();
    write_reg(cwm_pkg::REG_COS, c);
    write_reg(cwm_pkg::REG_SIN, s);
    write_reg(cwm_pkg::REG_FOCAL, f);
    write_reg(cwm_pkg::REG_CENTER_X, cx);
    write_reg(cwm_pkg::REG_CENTER_Y, cy);
    write_reg(cwm_pkg::REG_GAIN, g);
    write_reg(cwm_pkg::REG_ORIGIN_X, ox);
    write_reg(cwm_pkg::REG_ORIGIN_Y, oy);
  endtask

  // low end, high end or anywhere between
  function automatic longint pick(input longint lo, input longint hi);
    int unsigned sel;
    sel = $urandom_range(5);
    if (sel == 0) return lo;
    if (sel == 1) return hi;
    return lo + longint'($urandom_range(int'(hi - lo)));
  endfunction

  task automatic random_geometry;
    write_all(pick(-65536, 65536), pick(-65536, 65536), pick(1, 65535),
              pick(0, 65535), pick(0, 65535), pick(0, 16777215),
              pick(-524288, 524287), pick(-524288, 524287));
  endtask

  initial begin
    setup_t cur;
    int unsigned col, row;
    bit refimg;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel_col = '0;
    in_pixel_row = '0;
    in_pixel_color = '0;
    in_reference_image = 1'b0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    checked = 0;
    pixels_sent = 0;
    cycles = 0;
    hold_left = 0;
    tx_idle_pct = 38;
    rx_idle_pct = 84;
    cam_cos = 65536; cam_sin = 0; focal = 16384; cen_x = 0; cen_y = 0;
    gain = 262144; origin_x = 0; origin_y = 0; col_shift = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pixels, geometry switched where the table says
    cur = SET_RESET;
    foreach (directed[k]) begin
      if (directed[k].setup != cur) begin
        cur = directed[k].setup;
        if (cur == SET_FOLD)
          write_all(-65536, 0, 16384, 32768, 32768, 262144, 0, 0);
        else
          write_all(65536, 0, 0, 80, 80, 16777215, 524287, -524288);
      end
      send_pixel(directed[k].col, directed[k].row, directed[k].color, directed[k].refimg,
                 directed[k].typed, directed[k].ecol, directed[k].erow);
    end

    // an index past the last register must change nothing
    drain();
    write_reg(8'd8, 24'hffffff);
    write_reg(8'd255, 24'h000000);
    for (int k = 0; k < 20; k++)
      send_pixel($urandom_range(4095), $urandom_range(4095), $urandom, $urandom_range(1),
                 1'b0, 0, 0);

    // random geometry phases over three idle patterns
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 4) begin
        tx_idle_pct = 84;
        rx_idle_pct = 38;
      end else if (ph == 7) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (ph == 0)
        write_all(65536, -65536, 65535, 0, 65535, 0, 524287, 524287);
      else if (ph == 9)
        write_all(-65536, 65536, 1, 65535, 0, 16777215, -524288, -524288);
      else
        random_geometry();
      // long receiver hold while the sender keeps offering
      if (ph == 8) hold_left = 400;
      for (int k = 0; k < 150; k++) begin
        if ($urandom_range(9) == 0) begin
          col = 0; row = 0; refimg = 1'b1;
        end else begin
          col = $urandom_range(4095);
          row = $urandom_range(4095);
          refimg = $urandom_range(1);
        end
        send_pixel(col, row, $urandom, refimg, 1'b0, 0, 0);
      end
    end

    drain();
    $display("%0d pixels sent, %0d positions checked across 13 geometries", pixels_sent,
             checked);
    $display("covered fold, left half-plane, zero ray, shift latch and a long output hold");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
